>>> src/xs1024_pkg.sv
package xs1024_pkg;

    localparam int WORD_W      = 64;
    localparam int WORD_COUNT  = 16;
    localparam int INDEX_W     = 4;
    localparam int SEED_STEPS  = 17;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [INDEX_W-1:0] index_t;

    localparam word_t MULT_64STAR   = 64'd2685821657736338717;
    localparam word_t MULT_1024STAR = 64'd1181783497276652981;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        word_t nxt_pair1;
        word_t result;
    } xs128_out_t;

    function automatic word_t xs64_shift(input word_t x);
        word_t v;
        v = x;
        v = v ^ (v >> 12);
        v = v ^ (v << 25);
        v = v ^ (v >> 27);
        return v;
    endfunction

    function automatic xs128_out_t xs128_step(input word_t p0, input word_t p1);
        word_t      a;
        xs128_out_t r;
        a = p0 ^ (p0 << 23);
        r.nxt_pair1 = a ^ p1 ^ (a >> 17) ^ (p1 >> 26);
        r.result    = r.nxt_pair1 + p1;
        return r;
    endfunction

    function automatic word_t xs1024_mix(input word_t w0, input word_t w1);
        word_t t0;
        word_t t1;
        t1 = w1 ^ (w1 << 31);
        t1 = t1 ^ (t1 >> 11);
        t0 = w0 ^ (w0 >> 30);
        return t0 ^ t1;
    endfunction

endpackage

>>> src/xs1024_mul.sv
// 64x64 -> low 64 bits, one 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo.
module xs1024_mul
    import xs1024_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output logic     done,
    output word_t    product
);

    logic       running_reg;
    logic [1:0] phase_reg;
    logic       done_reg;
    word_t      a_reg;
    word_t      b_reg;
    word_t      acc_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] pp;

    always_comb begin
        case (phase_reg)
            2'd0: begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1: begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default: begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
    end

    assign pp = {32'd0, op_x} * {32'd0, op_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            phase_reg   <= 2'd0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= running_reg && (phase_reg == 2'd2);
            if (req.start) begin
                running_reg <= 1'b1;
                phase_reg   <= 2'd0;
            end else if (running_reg) begin
                if (phase_reg == 2'd2) begin
                    running_reg <= 1'b0;
                end
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end else if (running_reg) begin
            if (phase_reg == 2'd0) begin
                acc_reg <= pp;
            end else begin
                acc_reg <= acc_reg + {pp[31:0], 32'd0};
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.start && running_reg))
        else $error("multiplier restarted while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !running_reg)
        else $error("done raised while still running");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (phase_reg != 2'd3))
        else $error("multiplier phase out of range");

endmodule

>>> src/xorshift1024_star_generator.sv
// Channel   Dir  Handshake            Payload (low bit up)
// s_        in   s_tvalid/s_tready    s_tdata: seed[63:0]; s_tuser: func (1 = reseed)
// m_        out  m_tvalid/m_tready    m_tdata: random_value[63:0]
//
// Draw: mix/write-back with multiplier start, the multiplier's partial products, then load
// into the result register; the next request is taken in the cycle after the load.
// Reseed: two passes through the multiplier for the xorshift64* words, then the xorshift128+
// steps (index, then one state word a cycle); the next request is taken back in idle.
// One request in flight; a new request is taken while a result waits in m_.
// Reset: state reads as zero through per-word valid bits, index zero; no clear pass.
// A stalled result holds the pipeline in its final wait state only.
module xorshift1024_star_generator
    import xs1024_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // seed[63:0]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // random_value[63:0]
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MIX  = 7'b0000010,
        ST_DMUL = 7'b0000100,
        ST_DOUT = 7'b0001000,
        ST_S64  = 7'b0010000,
        ST_S64W = 7'b0100000,
        ST_S128 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    index_t index_reg, index_next;
    word_t  s0_reg, s0_next;
    word_t  x_reg, x_next;
    word_t  pair0_reg, pair0_next;
    word_t  pair1_reg, pair1_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [WORD_COUNT-1:0] valid_reg;
    logic  out_valid_reg;
    word_t out_data_reg;

    word_t mem [WORD_COUNT];
    word_t rd_data_reg;
    logic  rd_valid_reg;

    logic     mem_we;
    index_t   mem_waddr;
    word_t    mem_wdata;
    index_t   nxt_idx;
    index_t   seed_addr;
    word_t    w1;
    word_t    mix_word;
    word_t    xs64_v;
    xs128_out_t xs;
    mul_req_t mul_req;
    logic     mul_done;
    word_t    mul_prod;
    logic     out_free;
    logic     out_load;

    xs1024_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign nxt_idx   = index_reg + index_t'(1);
    assign seed_addr = cnt_reg[INDEX_W-1:0] - index_t'(1);
    assign w1        = rd_valid_reg ? rd_data_reg : '0;
    assign mix_word  = xs1024_mix(s0_reg, w1);
    assign xs64_v    = xs64_shift(x_reg);
    assign xs        = xs128_step(pair0_reg, pair1_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        index_next = index_reg;
        s0_next    = s0_reg;
        x_next     = x_reg;
        pair0_next = pair0_reg;
        pair1_next = pair1_reg;
        cnt_next   = cnt_reg;
        mem_we     = 1'b0;
        mem_waddr  = nxt_idx;
        mem_wdata  = mix_word;
        mul_req    = '{start: 1'b0, a: mix_word, b: MULT_1024STAR};
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        x_next     = s_tdata;
                        cnt_next   = 5'd0;
                        state_next = ST_S64;
                    end else begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                mem_we        = 1'b1;
                s0_next       = mix_word;
                index_next    = nxt_idx;
                mul_req.start = 1'b1;
                state_next    = ST_DMUL;
            end
            ST_DMUL: begin
                if (mul_done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DOUT;
                    end
                end
            end
            ST_DOUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_S64: begin
                x_next     = xs64_v;
                mul_req    = '{start: 1'b1, a: xs64_v, b: MULT_64STAR};
                state_next = ST_S64W;
            end
            ST_S64W: begin
                if (mul_done) begin
                    if (cnt_reg == 5'd0) begin
                        pair0_next = mul_prod;
                        cnt_next   = 5'd1;
                        state_next = ST_S64;
                    end else begin
                        pair1_next = mul_prod;
                        cnt_next   = 5'd0;
                        state_next = ST_S128;
                    end
                end
            end
            ST_S128: begin
                pair0_next = pair1_reg;
                pair1_next = xs.nxt_pair1;
                if (cnt_reg == 5'd0) begin
                    index_next = xs.result[INDEX_W-1:0];
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = seed_addr;
                    mem_wdata = xs.result;
                    if (seed_addr == index_reg) begin
                        s0_next = xs.result;
                    end
                end
                if (cnt_reg == 5'(SEED_STEPS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            index_reg     <= '0;
            s0_reg        <= '0;
            cnt_reg       <= 5'd0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            index_reg <= index_next;
            s0_reg    <= s0_next;
            cnt_reg   <= cnt_next;
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        pair0_reg <= pair0_next;
        pair1_reg <= pair1_next;
        if (out_load) begin
            out_data_reg <= mul_prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_IDLE) begin
            rd_data_reg  <= mem[nxt_idx];
            rd_valid_reg <= valid_reg[nxt_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_DMUL || state_reg == ST_S64W))
        else $error("multiplier result arrived with no consumer waiting");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_MIX || state_reg == ST_S128))
        else $error("state RAM written outside mix or reseed fill");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten while holding a result");

    a_seed_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 5'(SEED_STEPS - 1))
        else $error("reseed step count out of range");

endmodule

>>> verif/tb_xorshift1024_star_generator.sv
`timescale 1ns / 100ps

module tb_xorshift1024_star_generator;
    import xs1024_pkg::*;

    typedef enum bit {
        REQ_DRAW   = 1'b0,
        REQ_RESEED = 1'b1
    } req_kind_e;

    typedef struct {
        req_kind_e kind;
        word_t     seed;
    } gen_req_t;

    localparam word_t SEED_MUL = 64'd2685821657736338717;
    localparam word_t OUT_MUL  = 64'd1181783497276652981;
    localparam int    RANDOM_ITEMS = 1300;
    localparam int    QUIET_LIMIT  = 3000;
    localparam int    LONG_HOLD    = 250;
    localparam int    DRAIN_CYCLES = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    gen_req_t pending_reqs[$];
    word_t    random_due[$];
    word_t    gen_words[WORD_COUNT] = '{default: '0};
    index_t   gen_ptr = '0;

    int total_reqs    = 0;
    int accepted_reqs = 0;
    int draws_taken   = 0;
    int reseeds_taken = 0;
    int results_seen  = 0;
    int zero_results  = 0;
    int error_cnt     = 0;
    int send_gap      = 0;
    int sink_gap      = 0;
    int quiet_cycles  = 0;
    bit send_steady   = 1'b0;
    bit sink_steady   = 1'b0;
    bit long_hold_done = 1'b0;

    xorshift1024_star_generator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic word_t seed_chain_step(ref word_t x);
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x * SEED_MUL;
    endfunction

    // seed -> xorshift64* pair -> xorshift128+ stream: index, then words 0..15
    function automatic void apply_reseed(input word_t seed);
        word_t x;
        word_t p0;
        word_t p1;
        word_t a;
        word_t nxt;
        word_t out;
        x  = seed;
        p0 = seed_chain_step(x);
        p1 = seed_chain_step(x);
        for (int k = 0; k <= WORD_COUNT; k++) begin
            a   = p0 ^ (p0 << 23);
            nxt = a ^ p1 ^ (a >> 17) ^ (p1 >> 26);
            out = nxt + p1;
            p0  = p1;
            p1  = nxt;
            if (k == 0) begin
                gen_ptr = out[INDEX_W-1:0];
            end else begin
                gen_words[k-1] = out;
            end
        end
    endfunction

    function automatic word_t next_random();
        index_t nxt;
        word_t  w0;
        word_t  w1;
        nxt = gen_ptr + 1'b1;
        w0  = gen_words[gen_ptr];
        w1  = gen_words[nxt];
        w1  = w1 ^ (w1 << 31);
        w1  = w1 ^ (w1 >> 11);
        w0  = w0 ^ (w0 >> 30);
        gen_words[nxt] = w0 ^ w1;
        gen_ptr = nxt;
        return gen_words[nxt] * OUT_MUL;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t random_seed();
        case ($urandom_range(0, 9))
            0: return word_t'(1) << $urandom_range(0, 63);
            1: return '0;
            2: return ~(word_t'(1) << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_req(input req_kind_e kind, input word_t seed);
        gen_req_t r;
        r.kind = kind;
        r.seed = seed;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // driver
    always @(posedge aclk) begin
        gen_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_reqs++;
                if (s_tuser == REQ_RESEED) begin
                    reseeds_taken++;
                    apply_reseed(s_tdata);
                end else begin
                    draws_taken++;
                    random_due.push_back(next_random());
                end
                send_gap = pick_gap(send_steady);
                if ($urandom_range(0, 63) == 0)
                    send_steady = !send_steady;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= r.seed;
                    s_tuser  <= r.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tdata == '0)
                    zero_results++;
                if (random_due.size() == 0) begin
                    error_cnt++;
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                end else begin
                    want = random_due.pop_front();
                    if (m_tdata !== want) begin
                        error_cnt++;
                        $display("%0t: random_value mismatch, expected %h, got %h",
                                 $time, want, m_tdata);
                    end
                end
                sink_gap = pick_gap(sink_steady);
                if ($urandom_range(0, 63) == 0)
                    sink_steady = !sink_steady;
            end
            // one long back-pressure window so the input side stalls
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                sink_gap = LONG_HOLD;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int run_len;
        int rnd_count;

        // draws from the all-zero reset state stay at zero
        repeat (3) add_req(REQ_DRAW, '1);
        add_req(REQ_RESEED, '0);
        repeat (2) add_req(REQ_DRAW, '0);
        add_req(REQ_RESEED, '1);
        repeat (3) add_req(REQ_DRAW, 64'h0123_4567_89ab_cdef);
        add_req(REQ_RESEED, 64'h1);
        add_req(REQ_DRAW, '0);
        add_req(REQ_RESEED, 64'h8000_0000_0000_0000);
        add_req(REQ_DRAW, '1);
        // back-to-back reseeds, only the last one counts
        add_req(REQ_RESEED, 64'h5555_5555_5555_5555);
        add_req(REQ_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
        repeat (2) add_req(REQ_DRAW, 64'h5555_5555_5555_5555);

        rnd_count = 0;
        while (rnd_count < RANDOM_ITEMS) begin
            add_req(REQ_RESEED, random_seed());
            rnd_count++;
            if ($urandom_range(0, 7) == 0) begin
                add_req(REQ_RESEED, random_seed());
                rnd_count++;
            end
            run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 30);
            repeat (run_len) add_req(REQ_DRAW, {$urandom, $urandom});
            rnd_count += run_len;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_reqs < total_reqs)
            @(posedge aclk);
        while (random_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d draws and %0d reseeds (zero seed, single-bit and random seeds),",
                 draws_taken, reseeds_taken);
        $display("%0d results checked, %0d of them zero, with idle gaps and one long stall.",
                 results_seen, zero_results);
        if (error_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
